/* hw/rtl/tlpg_pkg.sv */
`timescale 1ns / 1ps

package tlpg_pkg;

  // Width of the three elapsed-time counters.
  localparam int TIME_WIDTH = 16;
  // Width of the held times from a command word.
  localparam int HOLD_WIDTH = 16;
  // Common width for comparing a counter with a held time.
  localparam int CMP_WIDTH  = (TIME_WIDTH > HOLD_WIDTH) ? TIME_WIDTH : HOLD_WIDTH;

  typedef enum logic [2:0] {
    BM_OFF       = 3'd0,
    BM_ON        = 3'd1,
    BM_TOGGLE    = 3'd2,
    BM_DELAY_ON  = 3'd3,
    BM_DELAY_OFF = 3'd4
  } base_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MODE  = 2'd1,
    ST_UNDEFINED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PROG_NOT_SET = 2'd0,
    PROG_IDLE    = 2'd1,
    PROG_BUSY    = 2'd2
  } progress_t;

  // One input word.
  typedef struct packed {
    logic        mode;
    logic [2:0]  base_mode;
    logic [15:0] pulse_time;
    logic [15:0] break_time;
    logic [15:0] total_on_time;
    logic [7:0]  repeat_count;
    logic [15:0] first_pitch;
    logic [15:0] second_pitch;
    logic [7:0]  volume;
    logic [15:0] light_level;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic        output_on;
    logic [15:0] pitch_out;
    logic [7:0]  volume_out;
    logic [15:0] light_out;
    logic [1:0]  progress;
  } result_t;

  // Handshake between the pipeline stages.
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_ctl_t;

  // Saturating increment of an elapsed counter.
  function automatic logic [TIME_WIDTH-1:0] bump(input logic [TIME_WIDTH-1:0] cnt);
    bump = (&cnt) ? cnt : cnt + TIME_WIDTH'(1);
  endfunction

  // True when a counter has reached a held time.
  function automatic logic reached(input logic [TIME_WIDTH-1:0] cnt,
                                   input logic [HOLD_WIDTH-1:0] lim);
    reached = CMP_WIDTH'(cnt) >= CMP_WIDTH'(lim);
  endfunction

endpackage

/* hw/rtl/tlpg_if.sv */
`timescale 1ns / 1ps

// Input channel: one command or tick word.
interface tlpg_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [2:0]  base_mode;
  logic [15:0] pulse_time;
  logic [15:0] break_time;
  logic [15:0] total_on_time;
  logic [7:0]  repeat_count;
  logic [15:0] first_pitch;
  logic [15:0] second_pitch;
  logic [7:0]  volume;
  logic [15:0] light_level;

  modport source (output valid, mode, base_mode, pulse_time, break_time, total_on_time,
                  repeat_count, first_pitch, second_pitch, volume, light_level,
                  input ready);
  modport sink (input valid, mode, base_mode, pulse_time, break_time, total_on_time,
                repeat_count, first_pitch, second_pitch, volume, light_level,
                output ready);
endinterface

// Output channel: one status word per input word.
interface tlpg_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        output_on;
  logic [15:0] pitch_out;
  logic [7:0]  volume_out;
  logic [15:0] light_out;
  logic [1:0]  progress;

  modport source (output valid, status, output_on, pitch_out, volume_out, light_out,
                  progress, input ready);
  modport sink (input valid, status, output_on, pitch_out, volume_out, light_out,
                progress, output ready);
endinterface

/* hw/rtl/tone_light_pattern_generator.sv */
`timescale 1ns / 1ps

// Channel   Role   Word
// items     sink   tick (mode 0) or pattern command (mode 1)
// results   source status, output state, pitch, loudness, brightness, progress
//
// Each word passes an input register and then the pattern logic into a result
// register, from which the result is offered; while results.ready stays high,
// one word per cycle is sustained.
// The state update and result compare logic sit between those two registers.
// Synchronous reset clears both stage valids and the pattern state (not set).
// A stalled result holds the output register; the input register still takes
// one more word, after which items.ready drops until results.ready returns.

module tone_light_pattern_generator
  import tlpg_pkg::*;
(
  input logic          clk,
  input logic          rst,
  tlpg_item_if.sink    items,
  tlpg_result_if.source results
);

  item_t      in_word;
  item_t      word;
  result_t    result;
  result_t    out_word;
  stage_ctl_t in_ctl;
  logic       load;

  assign in_word.mode          = items.mode;
  assign in_word.base_mode     = items.base_mode;
  assign in_word.pulse_time    = items.pulse_time;
  assign in_word.break_time    = items.break_time;
  assign in_word.total_on_time = items.total_on_time;
  assign in_word.repeat_count  = items.repeat_count;
  assign in_word.first_pitch   = items.first_pitch;
  assign in_word.second_pitch  = items.second_pitch;
  assign in_word.volume        = items.volume;
  assign in_word.light_level   = items.light_level;

  tlpg_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .in_word  (in_word),
    .ctl      (in_ctl),
    .take     (load),
    .word     (word)
  );

  tlpg_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (load),
    .word   (word),
    .result (result)
  );

  tlpg_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .up        (in_ctl),
    .load      (load),
    .in_word   (result),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_word  (out_word)
  );

  assign results.status     = out_word.status;
  assign results.output_on  = out_word.output_on;
  assign results.pitch_out  = out_word.pitch_out;
  assign results.volume_out = out_word.volume_out;
  assign results.light_out  = out_word.light_out;
  assign results.progress   = out_word.progress;

endmodule

/* hw/rtl/tlpg_in_stage.sv */
`timescale 1ns / 1ps

module tlpg_in_stage
  import tlpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_word,
  output stage_ctl_t ctl,
  input  logic       take,
  output item_t      word
);

  logic valid;

  // The register refills in the same cycle that its word moves on.
  assign in_ready  = !valid || take;
  assign ctl.valid = valid;
  assign ctl.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

/* hw/rtl/tlpg_engine.sv */
`timescale 1ns / 1ps

module tlpg_engine
  import tlpg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   word,
  output result_t result
);

  typedef struct packed {
    logic [2:0]            active_mode;
    progress_t             progress;
    logic                  phase_on;
    logic                  output_flag;
    logic [15:0]           current_pitch;
    logic [15:0]           pulse_time;
    logic [15:0]           break_time;
    logic [15:0]           total_time;
    logic [7:0]            repeat_count;
    logic [15:0]           first_pitch;
    logic [15:0]           second_pitch;
    logic [7:0]            volume;
    logic [15:0]           light;
    logic [TIME_WIDTH-1:0] pulse_elapsed;
    logic [TIME_WIDTH-1:0] break_elapsed;
    logic [TIME_WIDTH-1:0] command_elapsed;
    logic [7:0]            periods_done;
  } gen_state_t;

  gen_state_t state;
  gen_state_t state_next;
  status_t    status;

  // Next pattern state for a command or a tick.
  always_comb begin
    logic       limited;
    logic       load;
    logic       run_toggle;
    logic       ep;
    logic       eb;
    logic [7:0] periods_inc;

    state_next  = state;
    status      = ST_OK;
    load        = 1'b0;
    run_toggle  = 1'b0;
    ep          = 1'b0;
    eb          = 1'b0;
    periods_inc = (state.periods_done == 8'hFF) ? state.periods_done
                                                : state.periods_done + 8'd1;
    limited = (word.total_on_time != '0) || (word.repeat_count != '0) ||
              (word.second_pitch != '0);

    if (word.mode) begin
      // Command word.
      state_next.active_mode = word.base_mode;
      if (!limited) begin
        state_next.progress = PROG_IDLE;
        load = 1'b1;
      end else begin
        state_next.progress = PROG_BUSY;
        if (word.base_mode != BM_TOGGLE) begin
          status = ST_BAD_MODE;
        end else begin
          if (word.total_on_time != '0) begin
            state_next.command_elapsed = '0;
          end else begin
            state_next.periods_done = '0;
          end
          load = 1'b1;
        end
      end

      if (load) begin
        unique case (word.base_mode)
          BM_OFF: begin
            state_next.output_flag = 1'b0;
            state_next.progress    = PROG_IDLE;
          end
          BM_ON: begin
            state_next.output_flag   = 1'b1;
            state_next.first_pitch   = word.first_pitch;
            state_next.volume        = word.volume;
            state_next.light         = word.light_level;
            state_next.current_pitch = word.first_pitch;
            state_next.progress      = PROG_IDLE;
          end
          BM_TOGGLE: begin
            state_next.phase_on      = 1'b1;
            state_next.output_flag   = 1'b1;
            state_next.pulse_time    = word.pulse_time;
            state_next.break_time    = word.break_time;
            state_next.total_time    = word.total_on_time;
            state_next.repeat_count  = word.repeat_count;
            state_next.first_pitch   = word.first_pitch;
            state_next.second_pitch  = word.second_pitch;
            state_next.volume        = word.volume;
            state_next.light         = word.light_level;
            state_next.current_pitch = word.first_pitch;
            state_next.pulse_elapsed = '0;
          end
          BM_DELAY_ON, BM_DELAY_OFF: begin
            state_next.output_flag   = (word.base_mode == BM_DELAY_OFF);
            state_next.pulse_time    = word.pulse_time;
            state_next.break_time    = word.break_time;
            state_next.first_pitch   = word.first_pitch;
            state_next.volume        = word.volume;
            state_next.light         = word.light_level;
            state_next.current_pitch = word.first_pitch;
            state_next.progress      = PROG_BUSY;
            if (word.base_mode == BM_DELAY_ON) begin
              state_next.pulse_elapsed = '0;
            end else begin
              state_next.break_elapsed = '0;
            end
          end
          default: begin
            status = ST_BAD_MODE;
          end
        endcase
      end
    end else begin
      // Tick word: every elapsed counter advances first.
      state_next.pulse_elapsed   = bump(state.pulse_elapsed);
      state_next.break_elapsed   = bump(state.break_elapsed);
      state_next.command_elapsed = bump(state.command_elapsed);

      if (state.progress == PROG_NOT_SET) begin
        status = ST_UNDEFINED;
      end else begin
        unique case (state.active_mode)
          BM_OFF, BM_ON: begin
            status = ST_OK;
          end
          BM_TOGGLE: begin
            if (state.total_time != '0) begin
              if (reached(state_next.command_elapsed, state.total_time)) begin
                state_next.output_flag = 1'b0;
                state_next.phase_on    = 1'b0;
                state_next.progress    = PROG_IDLE;
              end else begin
                run_toggle = 1'b1;
              end
            end else if (state.repeat_count != '0) begin
              if (state.periods_done >= state.repeat_count &&
                  state.progress == PROG_IDLE) begin
                state_next.output_flag = 1'b0;
              end else begin
                run_toggle = 1'b1;
              end
            end else if (state.second_pitch != '0) begin
              if (state.periods_done != '0 && state.progress == PROG_IDLE) begin
                state_next.output_flag = 1'b0;
              end else begin
                run_toggle = 1'b1;
              end
            end else begin
              run_toggle = 1'b1;
            end
          end
          BM_DELAY_ON, BM_DELAY_OFF: begin
            if (state.pulse_time != '0 && state.break_time == '0) begin
              if (reached(state_next.pulse_elapsed, state.pulse_time)) begin
                state_next.output_flag   = 1'b1;
                state_next.current_pitch = state.first_pitch;
                state_next.progress      = PROG_IDLE;
              end else begin
                state_next.output_flag   = 1'b0;
                state_next.current_pitch = '0;
              end
            end else if (state.pulse_time == '0 && state.break_time != '0) begin
              if (reached(state_next.break_elapsed, state.break_time)) begin
                state_next.output_flag   = 1'b0;
                state_next.current_pitch = '0;
                state_next.progress      = PROG_IDLE;
              end else begin
                state_next.output_flag   = 1'b1;
                state_next.current_pitch = state.first_pitch;
              end
            end else begin
              status = ST_UNDEFINED;
            end
          end
          default: begin
            status = ST_BAD_MODE;
          end
        endcase
      end

      // Pulse and break phases of the toggle pattern.
      if (run_toggle) begin
        if (state.pulse_time == '0 || state.break_time == '0) begin
          status = ST_UNDEFINED;
        end else begin
          ep = reached(state_next.pulse_elapsed, state.pulse_time);
          eb = reached(state_next.break_elapsed, state.break_time);
          if (state.phase_on) begin
            if (ep) begin
              state_next.break_elapsed = '0;
              state_next.phase_on      = 1'b0;
              state_next.current_pitch = state.second_pitch;
            end
          end else if (eb) begin
            state_next.pulse_elapsed = '0;
            if (state.repeat_count != '0) begin
              state_next.periods_done = periods_inc;
              if (periods_inc >= state.repeat_count) begin
                state_next.phase_on = 1'b0;
                state_next.progress = PROG_IDLE;
              end else begin
                state_next.phase_on      = 1'b1;
                state_next.current_pitch = state.first_pitch;
              end
            end else if (state.second_pitch != '0) begin
              state_next.periods_done  = periods_inc;
              state_next.current_pitch = '0;
              state_next.phase_on      = 1'b0;
              state_next.progress      = PROG_IDLE;
            end else begin
              state_next.phase_on      = 1'b1;
              state_next.current_pitch = state.first_pitch;
            end
          end
          if (state.second_pitch == '0) begin
            state_next.output_flag = state_next.phase_on;
          end
        end
      end
    end
  end

  // Result fields come from the state after this word.
  always_comb begin
    result.status     = status;
    result.output_on  = state_next.output_flag;
    result.pitch_out  = state_next.current_pitch;
    result.volume_out = state_next.volume;
    result.light_out  = state_next.light;
    result.progress   = state_next.progress;
  end

  // All zeros is the reset state, with progress not set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/tlpg_out_stage.sv */
`timescale 1ns / 1ps

module tlpg_out_stage
  import tlpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t up,
  output logic       load,
  input  result_t    in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_word
);

  // A new word is loaded whenever the register is free or being emptied.
  assign load = up.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= in_word;
    end
  end

endmodule
